// ===== hdl/optical_power_alarm_scanner_unit_assert.svh =====
// Assertion macros shared by the scanner modules.
// Relies on the including module having signals named clock and reset.
`ifndef OPTICAL_POWER_ALARM_SCANNER_UNIT_ASSERT_SVH
`define OPTICAL_POWER_ALARM_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define OPAS_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("opas assertion failed");

// Next-cycle implication, checked outside reset
`define OPAS_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("opas assertion failed");

`endif

// ===== hdl/opas_pkg.sv =====
// Package of the optical power alarm scanner: sizes, codes, beat types.
// No dependencies; used by every module of the block.
package opas_pkg;

   localparam int LINES   = 8;
   localparam int LINE_W  = 3;
   localparam int CNT_W   = $clog2(LINES + 1);
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int FILL_W  = $clog2(QDEPTH + 1);

   localparam logic [LINE_W:0]   LINE_LIMIT  = (LINE_W + 1)'(LINES);
   localparam logic signed [15:0] POWER_RESET = 16'sd1024;

   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_REMOVE  = 2'd1,
      CMD_READING = 2'd2,
      CMD_POLL    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      OP_ADD,
      OP_REMOVE,
      OP_READING,
      OP_POLL,
      OP_SKIP
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [2:0]        line;
      logic [15:0]       station;
      logic [3:0]        priority_req;
      logic signed [15:0] threshold;
      logic [31:0]       interval;
      logic signed [15:0] power;
      logic [31:0]       now_time;
   } req_type;

   typedef struct packed {
      logic [2:0]  alarm_line;
      logic [15:0] alarm_station;
      logic [3:0]  alarm_priority;
      logic        is_repeat;
      logic        last;
   } rsp_type;

   // Classified command as held in the queue between front and back
   typedef struct packed {
      op_type             op;
      logic [LINE_W-1:0]  line;
      logic [15:0]        station;
      logic [3:0]         prio;
      logic signed [15:0] threshold;
      logic [31:0]        interval;
      logic signed [15:0] power;
      logic [31:0]        now_time;
   } work_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic     valid;
      work_type work;
   } head_type;

   // One entry of the alarm ordering list
   typedef struct packed {
      logic [LINE_W-1:0] line;
      logic [3:0]        prio;
      logic              rep;
   } slot_type;

endpackage

// ===== hdl/opas_front.sv =====
// Front end of the scanner: takes request beats, classifies them, queues them.
// Depends on opas_pkg and the assertion macro header.
`include "optical_power_alarm_scanner_unit_assert.svh"

module opas_front import opas_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_push,
   output logic     req_full,
   input  req_type  req_data,
   input  logic     head_pop,
   output head_type head
);

   work_type          queue_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   work_type          work;
   logic              line_ok;
   logic              enq;
   logic              deq;

   // Classify: out-of-range line numbers turn non-poll commands into no-ops
   always_comb begin
      line_ok        = {1'b0, req_data.line} < LINE_LIMIT;
      work.line      = req_data.line[LINE_W-1:0];
      work.station   = req_data.station;
      work.prio      = req_data.priority_req;
      work.threshold = req_data.threshold;
      work.interval  = req_data.interval;
      work.power     = req_data.power;
      work.now_time  = req_data.now_time;
      case (cmd_type'(req_data.cmd))
         CMD_ADD:     work.op = line_ok ? OP_ADD : OP_SKIP;
         CMD_REMOVE:  work.op = line_ok ? OP_REMOVE : OP_SKIP;
         CMD_READING: work.op = line_ok ? OP_READING : OP_SKIP;
         CMD_POLL:    work.op = OP_POLL;
         default:     work.op = OP_SKIP;
      endcase
   end

   // Queue bookkeeping; no-ops are accepted and dropped here
   assign req_full   = fill_ff == FILL_W'(QDEPTH);
   assign enq        = req_push && !req_full && (work.op != OP_SKIP);
   assign deq        = head_pop && head.valid;
   assign head.valid = fill_ff != '0;
   assign head.work  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = enq ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = deq ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + FILL_W'(enq) - FILL_W'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the classified beat
   always_ff @(posedge clock) begin
      if (enq) begin
         queue_ff[wr_ptr_ff] <= work;
      end
   end

   `OPAS_ASSERT_NXT(a_full_holds, req_full && !head_pop, req_full)

endmodule

// ===== hdl/opas_back.sv =====
// Back end of the scanner: line table, poll scan, alarm ordering, result stage.
// Depends on opas_pkg and the assertion macro header.
`include "optical_power_alarm_scanner_unit_assert.svh"

module opas_back import opas_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  head_type head,
   output logic     head_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output rsp_type  rsp_data
);

   // Line table
   logic               valid_ff     [LINES];
   logic               active_ff    [LINES];
   logic signed [15:0] power_ff     [LINES];
   logic [15:0]        station_ff   [LINES];
   logic [3:0]         prio_ff      [LINES];
   logic signed [15:0] threshold_ff [LINES];
   logic [31:0]        interval_ff  [LINES];
   logic [31:0]        next_ff      [LINES];

   // Control
   state_type         state_ff, state_in;
   logic [LINE_W-1:0] scan_ff, scan_in;
   logic [31:0]       now_ff, now_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   slot_type          slot_ff [LINES];
   slot_type          slot_in [LINES];
   rsp_type           rsp_ff, rsp_in;
   logic              out_full_ff, out_full_in;

   // Datapath
   logic [LINE_W-1:0]  rd_idx;
   logic               r_valid, r_active, below, first_hit, rep_hit, hit, recover;
   logic [31:0]        next_sum;
   logic               last_scan;
   logic               emit_load;
   logic               cmd_take;
   logic [LINES-1:0]   gt;
   slot_type           new_slot;

   // Read one table row: scan row while scanning, head alarm row while emitting
   assign rd_idx   = (state_ff == ST_EMIT) ? slot_ff[0].line : scan_ff;
   assign r_valid  = valid_ff[rd_idx];
   assign r_active = active_ff[rd_idx];
   assign below    = power_ff[rd_idx] < threshold_ff[rd_idx];
   assign next_sum = (r_active ? next_ff[rd_idx] : now_ff) + interval_ff[rd_idx];

   // Classify the scanned line
   always_comb begin
      first_hit = r_valid && below && !r_active;
      rep_hit   = r_valid && below && r_active && (now_ff >= next_ff[rd_idx]);
      recover   = r_valid && !below && r_active;
      hit       = (state_ff == ST_SCAN) && (first_hit || rep_hit);
      last_scan = scan_ff == LINE_W'(LINES - 1);
      new_slot.line = scan_ff;
      new_slot.prio = prio_ff[rd_idx];
      new_slot.rep  = rep_hit;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid && head.work.op == OP_POLL) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_scan) begin
               state_in = (count_ff != '0 || hit) ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (emit_load && count_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      cmd_take  = (state_ff == ST_IDLE) && head.valid;
      head_pop  = cmd_take;
      emit_load = (state_ff == ST_EMIT) && (!out_full_ff || rsp_pop);
   end

   // Ordering list: insert by priority during the scan, drop the head on emit
   always_comb begin
      for (int k = 0; k < LINES; k++) begin
         gt[k] = (CNT_W'(k) < count_ff) && (slot_ff[k].prio > new_slot.prio);
      end
      for (int k = 0; k < LINES; k++) begin
         slot_in[k] = slot_ff[k];
      end
      count_in = count_ff;
      if (hit) begin
         count_in = count_ff + 1'b1;
         if (gt[0] || count_ff == '0) begin
            slot_in[0] = new_slot;
         end
         for (int k = 1; k < LINES; k++) begin
            if (gt[k] || CNT_W'(k) == count_ff) begin
               slot_in[k] = gt[k-1] ? slot_ff[k-1] : new_slot;
            end
         end
      end else if (emit_load) begin
         count_in = count_ff - 1'b1;
         for (int k = 0; k < LINES - 1; k++) begin
            slot_in[k] = slot_ff[k+1];
         end
      end
   end

   // Scan index and poll time
   always_comb begin
      scan_in = scan_ff;
      now_in  = now_ff;
      if (cmd_take && head.work.op == OP_POLL) begin
         scan_in = '0;
         now_in  = head.work.now_time;
      end else if (state_ff == ST_SCAN) begin
         scan_in = scan_ff + 1'b1;
      end
   end

   // Result stage
   always_comb begin
      rsp_in      = rsp_ff;
      out_full_in = out_full_ff && !rsp_pop;
      if (emit_load) begin
         rsp_in.alarm_line     = slot_ff[0].line;
         rsp_in.alarm_station  = station_ff[rd_idx];
         rsp_in.alarm_priority = slot_ff[0].prio;
         rsp_in.is_repeat      = slot_ff[0].rep;
         rsp_in.last           = count_ff == CNT_W'(1);
         out_full_in           = 1'b1;
      end
   end

   assign rsp_empty = !out_full_ff;
   assign rsp_data  = rsp_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         out_full_ff <= out_full_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      now_ff  <= now_in;
      rsp_ff  <= rsp_in;
      for (int k = 0; k < LINES; k++) begin
         slot_ff[k] <= slot_in[k];
      end
   end

   // Table flags cleared and power set to POWER_RESET by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LINES; k++) begin
            valid_ff[k]  <= 1'b0;
            active_ff[k] <= 1'b0;
            power_ff[k]  <= POWER_RESET;
         end
      end else if (cmd_take) begin
         case (head.work.op)
            OP_ADD: begin
               valid_ff[head.work.line]  <= 1'b1;
               active_ff[head.work.line] <= 1'b0;
            end
            OP_REMOVE: begin
               valid_ff[head.work.line]  <= 1'b0;
               active_ff[head.work.line] <= 1'b0;
            end
            OP_READING: power_ff[head.work.line] <= head.work.power;
            default: ;
         endcase
      end else if (state_ff == ST_SCAN) begin
         if (first_hit) begin
            active_ff[scan_ff] <= 1'b1;
         end else if (recover) begin
            active_ff[scan_ff] <= 1'b0;
         end
      end
   end

   // Table fields without reset
   always_ff @(posedge clock) begin
      if (cmd_take && head.work.op == OP_ADD) begin
         station_ff[head.work.line]   <= head.work.station;
         prio_ff[head.work.line]      <= head.work.prio;
         threshold_ff[head.work.line] <= head.work.threshold;
         interval_ff[head.work.line]  <= head.work.interval;
         next_ff[head.work.line]      <= head.work.now_time;
      end else if (state_ff == ST_SCAN && (first_hit || rep_hit)) begin
         next_ff[scan_ff] <= next_sum;
      end
   end

   `OPAS_ASSERT_IMP(a_emit_has_alarm, state_ff == ST_EMIT, count_ff != '0)
   `OPAS_ASSERT_IMP(a_idle_list_empty, state_ff == ST_IDLE, count_ff == '0)
   `OPAS_ASSERT_NXT(a_last_closes_poll, emit_load && count_ff == CNT_W'(1), state_ff == ST_IDLE && out_full_ff && rsp_ff.last)

endmodule

// ===== hdl/optical_power_alarm_scanner_unit.sv =====
// Top level of the optical power alarm scanner.
// Depends on opas_pkg, opas_front and opas_back.

// The scanner keeps a table of LINES monitored optical lines and answers poll
// commands with alarm beats, ordered by priority and then line number, with the
// final beat of a poll marked last. Requests enter a four-entry command queue,
// so the front keeps taking beats while the back works or a result waits.
// An add, remove or power reading is applied to the table by the back end; a poll
// scans the table one line per cycle through one shared compare and time adder,
// then emits its alarms through the single result register, which holds while a
// result waits to be taken.
// Commands with a line number outside the table are accepted and dropped.
module optical_power_alarm_scanner_unit import opas_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   head_type head;
   logic     head_pop;

   opas_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .head_pop (head_pop),
      .head     (head)
   );

   opas_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .head_pop  (head_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== dv/tb_optical_power_alarm_scanner_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the optical power alarm scanner.
// Needs opas_pkg and optical_power_alarm_scanner_unit; predicts alarms in-line.

module tb_optical_power_alarm_scanner_unit;
   import opas_pkg::*;

   localparam int unsigned RANDOM_BEATS  = 128;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned SETTLE_CYCLES = 80;
   localparam int unsigned MAX_REPORTS   = 10;
   localparam int unsigned TIMEOUT_NS    = 2_000_000;

   typedef enum int {RX_STREAM, RX_RANDOM, RX_THROTTLE} rx_mode_type;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop  = 1'b0;
   rsp_type rsp_data;

   // Line table as the scanner should hold it
   logic               line_ok      [LINES] = '{default: 1'b0};
   logic [15:0]        tab_station  [LINES] = '{default: '0};
   logic [3:0]         tab_prio     [LINES] = '{default: '0};
   logic signed [15:0] tab_thresh   [LINES] = '{default: '0};
   logic [31:0]        tab_interval [LINES] = '{default: '0};
   logic               alarm_on     [LINES] = '{default: 1'b0};
   logic [31:0]        next_due     [LINES] = '{default: '0};
   logic signed [15:0] line_pwr     [LINES] = '{default: POWER_RESET};

   rsp_type     pending_alarms[$];
   int unsigned err_count   = 0;
   int unsigned burst_left  = 0;
   bit          steady_send = 1'b0;
   int unsigned hold_reqs   = 0;
   int unsigned hold_seen   = 0;
   int unsigned hold_left   = 0;
   rx_mode_type rx_mode     = RX_STREAM;
   int unsigned rx_mode_left = 0;
   int unsigned rx_tick     = 0;
   rsp_type     want;

   optical_power_alarm_scanner_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   initial begin
      #(TIMEOUT_NS);
      $display("optical_power_alarm_scanner_unit: mismatch");
      $finish;
   end

   task automatic note_fault(input string what);
      err_count++;
      if (err_count <= MAX_REPORTS) begin
         $display("[%0t] %s", $time, what);
      end
   endtask

   // Apply one accepted command to the table and queue the alarms it raises
   task automatic track_command(input req_type beat);
      logic    hit [LINES];
      logic    rep [LINES];
      rsp_type batch[$];
      rsp_type r;
      case (cmd_type'(beat.cmd))
         CMD_ADD: begin
            line_ok[beat.line]      = 1'b1;
            tab_station[beat.line]  = beat.station;
            tab_prio[beat.line]     = beat.priority_req;
            tab_thresh[beat.line]   = beat.threshold;
            tab_interval[beat.line] = beat.interval;
            alarm_on[beat.line]     = 1'b0;
            next_due[beat.line]     = beat.now_time;
         end
         CMD_REMOVE: begin
            line_ok[beat.line]  = 1'b0;
            alarm_on[beat.line] = 1'b0;
         end
         CMD_READING: begin
            line_pwr[beat.line] = beat.power;
         end
         CMD_POLL: begin
            // scan: raise first alarms, due repeats, drop recovered lines
            for (int i = 0; i < LINES; i++) begin
               hit[i] = 1'b0;
               rep[i] = 1'b0;
               if (line_ok[i]) begin
                  if (line_pwr[i] < tab_thresh[i]) begin
                     if (!alarm_on[i]) begin
                        alarm_on[i] = 1'b1;
                        next_due[i] = beat.now_time + tab_interval[i];
                        hit[i]      = 1'b1;
                     end else if (beat.now_time >= next_due[i]) begin
                        next_due[i] = next_due[i] + tab_interval[i];
                        hit[i]      = 1'b1;
                        rep[i]      = 1'b1;
                     end
                  end else begin
                     alarm_on[i] = 1'b0;
                  end
               end
            end
            // order by priority, then line number
            for (int p = 0; p < 16; p++) begin
               for (int i = 0; i < LINES; i++) begin
                  if (hit[i] && tab_prio[i] == 4'(p)) begin
                     r.alarm_line     = LINE_W'(i);
                     r.alarm_station  = tab_station[i];
                     r.alarm_priority = tab_prio[i];
                     r.is_repeat      = rep[i];
                     r.last           = 1'b0;
                     batch.push_back(r);
                  end
               end
            end
            if (batch.size() != 0) begin
               batch[batch.size() - 1].last = 1'b1;
            end
            foreach (batch[k]) begin
               pending_alarms.push_back(batch[k]);
            end
         end
         default: begin
         end
      endcase
   endtask

   function automatic req_type noise_beat();
      logic [127:0] raw;
      raw = {$urandom, $urandom, $urandom, $urandom};
      return raw[$bits(req_type)-1:0];
   endfunction

   function automatic req_type cmd_add(input int unsigned ln, input int unsigned sta,
                                       input int unsigned pr, input int thr,
                                       input logic [31:0] ivl, input logic [31:0] at);
      req_type b;
      b              = noise_beat();
      b.cmd          = CMD_ADD;
      b.line         = 3'(ln);
      b.station      = 16'(sta);
      b.priority_req = 4'(pr);
      b.threshold    = 16'(thr);
      b.interval     = ivl;
      b.now_time     = at;
      return b;
   endfunction

   function automatic req_type cmd_remove(input int unsigned ln);
      req_type b;
      b      = noise_beat();
      b.cmd  = CMD_REMOVE;
      b.line = 3'(ln);
      return b;
   endfunction

   function automatic req_type cmd_reading(input int unsigned ln, input int pw);
      req_type b;
      b       = noise_beat();
      b.cmd   = CMD_READING;
      b.line  = 3'(ln);
      b.power = 16'(pw);
      return b;
   endfunction

   function automatic req_type cmd_poll(input logic [31:0] at);
      req_type b;
      b          = noise_beat();
      b.cmd      = CMD_POLL;
      b.now_time = at;
      return b;
   endfunction

   // Offer one beat until taken; push stays up inside a burst, drops for a gap
   task automatic send_beat(input req_type beat);
      int unsigned gap;
      req_data <= beat;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full !== 1'b0);
      track_command(beat);
      if (!steady_send) begin
         if (burst_left != 0) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(0, 12);
            gap        = $urandom_range(1, 6);
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop offering, wait for every expected alarm, then let trailing work settle
   task automatic drain();
      req_push <= 1'b0;
      while (pending_alarms.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Empty table, field extremes, time wrap, equal power, remove twice
   task automatic test_extremes();
      send_beat(cmd_poll(32'h0000_0000));
      send_beat(cmd_add(0, 16'hFFFF, 15, 32767, 32'hFFFF_FFFF, 32'hFFFF_FFF0));
      send_beat(cmd_add(7, 16'h0000, 0, -32768, 32'h0000_0000, 32'h0000_0000));
      send_beat(cmd_reading(7, -32768));
      send_beat(cmd_poll(32'hFFFF_FFF0));
      send_beat(cmd_poll(32'hFFFF_FFF0));
      send_beat(cmd_reading(7, 32767));
      send_beat(cmd_poll(32'h0000_0000));
      send_beat(cmd_remove(0));
      send_beat(cmd_remove(0));
      send_beat(cmd_poll(32'hFFFF_FFFF));
      drain();
   endtask

   // Reading on an idle line, same-priority order, repeats, recovery, update
   task automatic test_repeat_and_recovery();
      send_beat(cmd_reading(5, -256));
      send_beat(cmd_add(3, 16'h1234, 5, 0, 32'd10, 32'd100));
      send_beat(cmd_reading(3, -1));
      send_beat(cmd_add(5, 16'hABCD, 5, 0, 32'd1, 32'd100));
      send_beat(cmd_poll(32'd100));
      send_beat(cmd_poll(32'd105));
      send_beat(cmd_poll(32'd110));
      send_beat(cmd_reading(3, 0));
      send_beat(cmd_poll(32'd111));
      send_beat(cmd_reading(3, -1));
      send_beat(cmd_poll(32'd112));
      send_beat(cmd_add(5, 16'h5A5A, 2, 0, 32'd3, 32'd112));
      send_beat(cmd_poll(32'd112));
      drain();
   endtask

   // Full table alarming every poll while the receiver holds off
   task automatic test_backpressure();
      logic [31:0] at;
      at          = 32'd5000;
      steady_send = 1'b1;
      for (int i = 0; i < LINES; i++) begin
         send_beat(cmd_reading(i, -32768));
         send_beat(cmd_add(i, $urandom, $urandom_range(0, 3), 32767, 32'd0, at));
      end
      hold_reqs <= hold_reqs + 1;
      repeat (12) begin
         at = at + 1;
         send_beat(cmd_poll(at));
      end
      steady_send = 1'b0;
      drain();
   endtask

   // Mostly add/reading/poll episodes near the thresholds, some raw noise
   task automatic test_random_traffic();
      int unsigned sent;
      int unsigned ln;
      int unsigned pick;
      logic [31:0] wall;
      sent = 0;
      wall = 32'd1000;
      while (sent < RANDOM_BEATS) begin
         if ($urandom_range(0, 9) < 2) begin
            send_beat(noise_beat());
            sent++;
         end else begin
            repeat ($urandom_range(1, 3)) begin
               ln = $urandom_range(0, LINES - 1);
               send_beat(cmd_add(ln, $urandom, $urandom_range(0, 15),
                                 int'($signed(16'($urandom))), $urandom_range(0, 4), wall));
               sent++;
            end
            repeat ($urandom_range(3, 8)) begin
               pick = $urandom_range(0, 19);
               ln   = $urandom_range(0, LINES - 1);
               if (pick < 9) begin
                  send_beat(cmd_reading(ln, int'(tab_thresh[ln]) + $urandom_range(0, 4) - 2));
               end else if (pick < 18) begin
                  wall = wall + $urandom_range(0, 3);
                  send_beat(cmd_poll(wall));
               end else begin
                  send_beat(cmd_remove(ln));
               end
               sent++;
            end
         end
      end
      drain();
   endtask

   // Receiver: long hold-off on request, otherwise rotating stall patterns
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            if (rx_mode_left == 0) begin
               rx_mode      = rx_mode_type'($urandom_range(0, 2));
               rx_mode_left = $urandom_range(8, 80);
            end else begin
               rx_mode_left--;
            end
            rx_tick++;
            case (rx_mode)
               RX_STREAM: rsp_pop <= 1'b1;
               RX_RANDOM: rsp_pop <= ($urandom_range(0, 3) != 0);
               default:   rsp_pop <= (rx_tick % 3 == 0);
            endcase
         end
      end
   end

   // Compare every accepted alarm beat with the oldest expected one
   always @(posedge clock) begin
      if (!reset && rsp_pop && rsp_empty !== 1'b1) begin
         if (pending_alarms.size() == 0) begin
            note_fault($sformatf({"unexpected alarm: line %0d station %h",
                                  " prio %0d rep %0b last %0b"},
                                 rsp_data.alarm_line, rsp_data.alarm_station,
                                 rsp_data.alarm_priority, rsp_data.is_repeat, rsp_data.last));
         end else begin
            want = pending_alarms.pop_front();
            if (rsp_data.alarm_line !== want.alarm_line ||
                rsp_data.alarm_station !== want.alarm_station ||
                rsp_data.alarm_priority !== want.alarm_priority ||
                rsp_data.is_repeat !== want.is_repeat ||
                rsp_data.last !== want.last) begin
               note_fault($sformatf({"alarm differs: exp line %0d sta %h prio %0d",
                                     " rep %0b last %0b,",
                                     " got line %0d sta %h prio %0d rep %0b last %0b"},
                                    want.alarm_line, want.alarm_station, want.alarm_priority,
                                    want.is_repeat, want.last,
                                    rsp_data.alarm_line, rsp_data.alarm_station,
                                    rsp_data.alarm_priority, rsp_data.is_repeat,
                                    rsp_data.last));
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_repeat_and_recovery();
      test_backpressure();
      test_random_traffic();
      if (err_count == 0 && pending_alarms.size() == 0) begin
         $display("optical_power_alarm_scanner_unit: match");
      end else begin
         $display("optical_power_alarm_scanner_unit: mismatch");
      end
      $finish;
   end

endmodule
